// ===== sv/assert_macros.svh =====
// Assertion macros used by spd_checker, the checker module of the size prefix decoder.
// Each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/spd_pkg.sv =====
// Types and constants of the size prefix decoder.
// Used by spd_core, size_prefix_decoder_top and tb_top; depends on nothing.
`timescale 1ns / 1ps

package spd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned OutW   = 40;

  localparam logic [7:0] Mask6 = 8'h3f;
  localparam logic [7:0] Mask5 = 8'h1f;
  localparam logic [7:0] Mask4 = 8'h0f;

  localparam logic [CountW-1:0] Len1 = 3'd1;
  localparam logic [CountW-1:0] Len2 = 3'd2;
  localparam logic [CountW-1:0] Len3 = 3'd3;
  localparam logic [CountW-1:0] Len4 = 3'd4;
  localparam logic [CountW-1:0] Len5 = 3'd5;

  typedef struct packed {
    logic [CountW-1:0] bytes_left;
    logic [ValueW-1:0] accumulator;
    logic [CountW-1:0] total_length;
  } spd_state_t;

  typedef struct packed {
    logic [CountW-1:0]        byte_count;
    logic signed [ValueW-1:0] size_value;
  } spd_result_t;

endpackage

// ===== sv/spd_core.sv =====
// Next-state and result logic of the size prefix decoder for one byte.
// Depends on spd_pkg.
`timescale 1ns / 1ps

module spd_core (
  input  spd_pkg::spd_state_t  st_i,
  input  logic [7:0]           data_byte_i,
  output spd_pkg::spd_state_t  st_o,
  output logic                 emit_o,
  output spd_pkg::spd_result_t res_o
);
  import spd_pkg::*;

  logic [ValueW-1:0] acc_shift;

  assign acc_shift = {st_i.accumulator[ValueW-ByteW-1:0], data_byte_i};

  always_comb begin
    st_o   = st_i;
    emit_o = 1'b0;
    res_o.size_value = acc_shift;
    res_o.byte_count = st_i.total_length;
    if (st_i.bytes_left == '0) begin
      case (data_byte_i[7:4]) inside
        4'b0???: begin
          emit_o = 1'b1;
          res_o.size_value = {{(ValueW-ByteW){1'b0}}, data_byte_i};
          res_o.byte_count = Len1;
        end
        4'b10??: begin
          st_o.accumulator  = {{(ValueW-ByteW){1'b0}}, data_byte_i & Mask6};
          st_o.bytes_left   = Len1;
          st_o.total_length = Len2;
        end
        4'b110?: begin
          st_o.accumulator  = {{(ValueW-ByteW){1'b0}}, data_byte_i & Mask5};
          st_o.bytes_left   = Len2;
          st_o.total_length = Len3;
        end
        4'b1110: begin
          st_o.accumulator  = {{(ValueW-ByteW){1'b0}}, data_byte_i & Mask4};
          st_o.bytes_left   = Len3;
          st_o.total_length = Len4;
        end
        default: begin
          st_o.accumulator  = '0;
          st_o.bytes_left   = Len4;
          st_o.total_length = Len5;
        end
      endcase
    end else begin
      st_o.accumulator = acc_shift;
      st_o.bytes_left  = st_i.bytes_left - Len1;
      if (st_i.bytes_left == Len1) begin
        emit_o            = 1'b1;
        st_o.accumulator  = '0;
        st_o.total_length = '0;
      end
    end
  end

endmodule

// ===== sv/size_prefix_decoder_top.sv =====
// Top level of the size prefix decoder: stream ports, state and result registers.
// Depends on spd_pkg and spd_core.
`timescale 1ns / 1ps

// Channel  Dir  Payload
// in_      in   tdata[7:0] data_byte
// out_     out  tdata[31:0] size_value, [34:32] byte_count, [39:35] zero
//
// One byte is taken per cycle unless the input is stalled; a result appears in the cycle after its last byte is taken.
// The decode state, the result register and its valid flag are the only stored elements.
// The input is stalled only while a result waits and out_tready is low.
// Reset drops a partly received value and clears the result valid flag; the result data itself is not reset.

module size_prefix_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [39:0] out_tdata  // [31:0] size_value, [34:32] byte_count, [39:35] zero
);
  import spd_pkg::*;

  spd_state_t  st_r;
  spd_state_t  st_nxt;
  spd_result_t res_r;
  spd_result_t res_nxt;
  logic        out_valid_r;
  logic        emit;
  logic        in_xfer;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  spd_core u_core (
    .st_i        (st_r),
    .data_byte_i (in_tdata),
    .st_o        (st_nxt),
    .emit_o      (emit),
    .res_o       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        st_r <= st_nxt;
      end
      if (in_xfer && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutW-ValueW-CountW){1'b0}}, res_r.byte_count, res_r.size_value};

endmodule

// ===== sv/spd_checker.sv =====
// Port-level checks of the size prefix decoder, bound to the top level.
// Depends on assert_macros.svh and size_prefix_decoder_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  logic [2:0] out_count;

  assign out_count = out_tdata[34:32];

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASSERT_IMPLY(a_count_range, clk, rst_n, out_tvalid, out_count >= 3'd1 && out_count <= 3'd5)
  `ASSERT_IMPLY(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[39:35] == 5'd0)
  `ASSERT_IMPLY(a_ready_empty, clk, rst_n, !out_tvalid, in_tready)
  `ASSERT_IMPLY(a_short_value, clk, rst_n, out_tvalid && out_count == 3'd1, out_tdata[31:7] == 25'd0)

endmodule

bind size_prefix_decoder_top spd_checker u_spd_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for size_prefix_decoder_top: drives encoded size bytes,
// predicts each decoded value and byte count, and checks them. Depends on spd_pkg and size_prefix_decoder_top.
`timescale 1ns / 1ps

module tb_top;
  import spd_pkg::*;

  class size_value_board;
    logic [CountW-1:0] bytes_left;
    logic [ValueW-1:0] gathered;
    logic [CountW-1:0] value_len;
    spd_result_t       pending_sizes[$];
    int                errors;

    function new();
      bytes_left = '0;
      gathered = '0;
      value_len = '0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void take_byte(input logic [7:0] b);
      spd_result_t done;
      if (bytes_left == 0) begin
        if (!b[7]) begin
          done.byte_count = Len1;
          done.size_value = {24'b0, b};
          pending_sizes.push_back(done);
        end else if (!b[6]) begin
          gathered = {24'b0, b & Mask6};
          bytes_left = 3'd1;
          value_len = Len2;
        end else if (!b[5]) begin
          gathered = {24'b0, b & Mask5};
          bytes_left = 3'd2;
          value_len = Len3;
        end else if (!b[4]) begin
          gathered = {24'b0, b & Mask4};
          bytes_left = 3'd3;
          value_len = Len4;
        end else begin
          gathered = '0;
          bytes_left = 3'd4;
          value_len = Len5;
        end
      end else begin
        gathered = {gathered[23:0], b};
        bytes_left = bytes_left - 3'd1;
        if (bytes_left == 0) begin
          done.byte_count = value_len;
          done.size_value = gathered;
          pending_sizes.push_back(done);
          gathered = '0;
          value_len = '0;
        end
      end
    endfunction

    task check_size(input logic [OutW-1:0] word);
      spd_result_t       want;
      logic [ValueW-1:0] got_value;
      logic [CountW-1:0] got_count;
      got_value = word[31:0];
      got_count = word[34:32];
      if (pending_sizes.size() == 0) begin
        report($sformatf("unexpected result value %0d count %0d",
                         $signed(got_value), got_count));
      end else begin
        want = pending_sizes.pop_front();
        if (got_value !== want.size_value) begin
          report($sformatf("size_value got %0d want %0d",
                           $signed(got_value), want.size_value));
        end
        if (got_count !== want.byte_count) begin
          report($sformatf("byte_count got %0d want %0d", got_count, want.byte_count));
        end
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  size_value_board sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bytes_sent = 0;

  size_prefix_decoder_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_size(out_tdata);
    end
  end

  task send_byte(input logic [7:0] b);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task send_encoding(input int len);
    logic [7:0] lead;
    logic [7:0] follow;
    lead = 8'($urandom_range(0, 255));
    case (len)
      1: begin
        lead[7] = 1'b0;
      end
      2: begin
        lead[7:6] = 2'b10;
      end
      3: begin
        lead[7:5] = 3'b110;
      end
      4: begin
        lead[7:4] = 4'b1110;
      end
      default: begin
        lead[7:4] = 4'b1111;
      end
    endcase
    send_byte(lead);
    repeat (len - 1) begin
      case ($urandom_range(0, 7))
        0: follow = 8'h00;
        1: follow = 8'hff;
        default: follow = 8'($urandom_range(0, 255));
      endcase
      send_byte(follow);
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    int         phase_start;
    int         drain_cycles;
    directed = '{8'h00, 8'h7f, 8'h80, 8'h00, 8'hbf, 8'hff, 8'hdf, 8'hff, 8'hff,
                 8'he0, 8'h00, 8'h00, 8'h00, 8'hff, 8'h80, 8'h00, 8'h00, 8'h00,
                 8'hf5, 8'h7f, 8'hff, 8'hff, 8'hff};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) begin
      send_byte(directed[i]);
    end
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 54;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 54;
        end
        default: begin
          send_idle_pct = 14;
          recv_stall_pct = 14;
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 200) begin
        if ($urandom_range(0, 9) == 0) begin
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_encoding($urandom_range(1, 5));
        end
      end
    end
    in_tvalid <= 1'b0;
    drain_cycles = 0;
    while (sb.pending_sizes.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (sb.pending_sizes.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending_sizes.size()));
    end
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
